>>> rtl/pbc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Point box clustering package
// Shared constants, register codes and the token control type that moves
// along the row of cluster cells.
// ----------------------------------------------------------------------------
package pbc_pkg;

  // Default size of the cluster table and coordinate width.
  localparam int MAX_CLUSTERS_DEF = 64;
  localparam int COORD_BITS_DEF   = 12;

  // Widths fixed by the channel and register definitions.
  localparam int FIELD_W     = 12;
  localparam int INDEX_OUT_W = 6;
  localparam int TOTAL_OUT_W = 7;
  localparam int CFG_IDX_W   = 1;

  // Threshold reset value.
  localparam logic [FIELD_W-1:0] THRESH_RESET = FIELD_W'(100);

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_X_THRESHOLD = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_Y_THRESHOLD = 1'b1;

  // Control part of the token handed from cell to cell.
  typedef struct packed {
    logic valid;
    logic found;
    logic opened;
  } pbc_tok_ctrl_t;

endpackage

>>> rtl/pbc_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Point box clustering channels
// Valid/ready channels for incoming points and for cluster results.
// ----------------------------------------------------------------------------
interface pbc_point_if;
  logic        valid;
  logic        ready;
  logic        start_set;
  logic [11:0] point_x;
  logic [11:0] point_y;

  modport source (output valid, start_set, point_x, point_y, input ready);
  modport sink (input valid, start_set, point_x, point_y, output ready);
endinterface

interface pbc_result_if;
  logic        valid;
  logic        ready;
  logic [5:0]  cluster_index;
  logic        opened_new;
  logic        table_full;
  logic [11:0] center_x;
  logic [11:0] center_y;
  logic [6:0]  cluster_total;

  modport source (output valid, cluster_index, opened_new, table_full, center_x, center_y,
                  cluster_total, input ready);
  modport sink (input valid, cluster_index, opened_new, table_full, center_x, center_y,
                cluster_total, output ready);
endinterface

>>> rtl/point_box_clustering_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Point box clustering unit
// Groups incoming points into bounding-box clusters with a row of cells.
//
//   Channel   Role   Handshake             Payload
//   points    sink   valid/ready           start_set, point_x, point_y
//   results   source valid/ready           index, flags, center, total
//   config    write  write_enable only     reg_index, write_data
//
// One point is in flight at a time. A point walks the whole cell row, one
// cell per cycle, then passes the hold stage and the output register before
// its result is presented. A new point is taken once the previous result
// has left the hold stage, even while the output register still waits for
// the sink. Reset is synchronous; it clears the control state and the cluster
// count and sets both thresholds to THRESH_RESET; no clearing pass runs.
// ----------------------------------------------------------------------------
module point_box_clustering_unit #(
  parameter int MAX_CLUSTERS = pbc_pkg::MAX_CLUSTERS_DEF,
  parameter int COORD_BITS   = pbc_pkg::COORD_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  pbc_point_if.sink                     points,
  pbc_result_if.source                  results,
  input  logic                          write_enable,
  input  logic [pbc_pkg::CFG_IDX_W-1:0] reg_index,
  input  logic [pbc_pkg::FIELD_W-1:0]   write_data
);
  import pbc_pkg::*;

  localparam int IDX_W = $clog2(MAX_CLUSTERS);
  localparam int CNT_W = $clog2(MAX_CLUSTERS + 1);

  // Configuration registers.
  logic [FIELD_W-1:0] x_threshold, y_threshold;

  always_ff @(posedge clk) begin
    if (rst) begin
      x_threshold <= THRESH_RESET;
      y_threshold <= THRESH_RESET;
    end else if (write_enable) begin
      case (reg_index)
        REG_X_THRESHOLD: x_threshold <= write_data;
        REG_Y_THRESHOLD: y_threshold <= write_data;
        default: ;
      endcase
    end
  end

  // Token chain between cells; stage 0 is the injection point.
  pbc_tok_ctrl_t         ctrl_c [MAX_CLUSTERS+1];
  logic [COORD_BITS-1:0] px_c   [MAX_CLUSTERS+1];
  logic [COORD_BITS-1:0] py_c   [MAX_CLUSTERS+1];
  logic [IDX_W-1:0]      idx_c  [MAX_CLUSTERS+1];
  logic [COORD_BITS-1:0] cx_c   [MAX_CLUSTERS+1];
  logic [COORD_BITS-1:0] cy_c   [MAX_CLUSTERS+1];
  logic [CNT_W-1:0]      used_c [MAX_CLUSTERS+1];

  logic              busy;
  logic              accept;
  logic [CNT_W-1:0]  clusters_used;

  assign points.ready = !busy;
  assign accept       = points.valid && !busy;

  // Inject a point; a start flag restarts the table at zero clusters.
  always_comb begin
    ctrl_c[0].valid  = accept;
    ctrl_c[0].found  = 1'b0;
    ctrl_c[0].opened = 1'b0;
    px_c[0]          = COORD_BITS'(points.point_x);
    py_c[0]          = COORD_BITS'(points.point_y);
    idx_c[0]         = '0;
    cx_c[0]          = '0;
    cy_c[0]          = '0;
    used_c[0]        = points.start_set ? '0 : clusters_used;
  end

  // Row of cluster cells.
  for (genvar g = 0; g < MAX_CLUSTERS; g++) begin : g_cell
    pbc_cell #(
      .CELL_ID    (g),
      .COORD_BITS (COORD_BITS),
      .IDX_W      (IDX_W),
      .CNT_W      (CNT_W)
    ) u_cell (
      .clk         (clk),
      .rst         (rst),
      .x_threshold (x_threshold),
      .y_threshold (y_threshold),
      .ctrl_prev   (ctrl_c[g]),
      .px_prev     (px_c[g]),
      .py_prev     (py_c[g]),
      .idx_prev    (idx_c[g]),
      .cx_prev     (cx_c[g]),
      .cy_prev     (cy_c[g]),
      .used_prev   (used_c[g]),
      .ctrl        (ctrl_c[g+1]),
      .px          (px_c[g+1]),
      .py          (py_c[g+1]),
      .idx         (idx_c[g+1]),
      .cx          (cx_c[g+1]),
      .cy          (cy_c[g+1]),
      .used        (used_c[g+1])
    );
  end

  // Token leaving the last cell carries the finished result.
  pbc_tok_ctrl_t    tail_ctrl;
  logic [CNT_W-1:0] tail_used;

  assign tail_ctrl = ctrl_c[MAX_CLUSTERS];
  assign tail_used = used_c[MAX_CLUSTERS];

  // Hold stage between the row and the output register.
  logic                   hold_valid;
  logic [INDEX_OUT_W-1:0] hold_index;
  logic                   hold_opened;
  logic                   hold_full;
  logic [FIELD_W-1:0]     hold_cx, hold_cy;
  logic [TOTAL_OUT_W-1:0] hold_total;
  logic                   hold_move;

  assign hold_move = hold_valid && (!results.valid || results.ready);

  always_ff @(posedge clk) begin
    if (rst) begin
      hold_valid <= 1'b0;
    end else if (tail_ctrl.valid) begin
      hold_valid <= 1'b1;
    end else if (hold_move) begin
      hold_valid <= 1'b0;
    end
  end

  // A dropped point reports zero index, center and opened flag with the full flag set.
  always_ff @(posedge clk) begin
    if (tail_ctrl.valid) begin
      hold_full   <= !tail_ctrl.found;
      hold_opened <= tail_ctrl.found && tail_ctrl.opened;
      hold_index  <= tail_ctrl.found ? INDEX_OUT_W'(idx_c[MAX_CLUSTERS]) : '0;
      hold_cx     <= tail_ctrl.found ? FIELD_W'(cx_c[MAX_CLUSTERS]) : '0;
      hold_cy     <= tail_ctrl.found ? FIELD_W'(cy_c[MAX_CLUSTERS]) : '0;
      hold_total  <= TOTAL_OUT_W'(tail_used);
    end
  end

  // Cluster count and busy flag.
  always_ff @(posedge clk) begin
    if (rst) begin
      clusters_used <= '0;
      busy          <= 1'b0;
    end else begin
      if (tail_ctrl.valid) begin
        clusters_used <= tail_used;
      end
      if (accept) begin
        busy <= 1'b1;
      end else if (hold_move) begin
        busy <= 1'b0;
      end
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      results.valid <= 1'b0;
    end else if (hold_move) begin
      results.valid <= 1'b1;
    end else if (results.ready) begin
      results.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (hold_move) begin
      results.cluster_index <= hold_index;
      results.opened_new    <= hold_opened;
      results.table_full    <= hold_full;
      results.center_x      <= hold_cx;
      results.center_y      <= hold_cy;
      results.cluster_total <= hold_total;
    end
  end

endmodule

>>> rtl/pbc_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Point box clustering cell
// Holds one cluster box. A token carrying a point passes through once per
// cycle; the first live cell that matches grows its box, and the first free
// cell opens a new box if no earlier cell took the point.
// ----------------------------------------------------------------------------
module pbc_cell #(
  parameter int CELL_ID    = 0,
  parameter int COORD_BITS = 12,
  parameter int IDX_W      = 6,
  parameter int CNT_W      = 7
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic [pbc_pkg::FIELD_W-1:0] x_threshold,
  input  logic [pbc_pkg::FIELD_W-1:0] y_threshold,
  input  pbc_pkg::pbc_tok_ctrl_t     ctrl_prev,
  input  logic [COORD_BITS-1:0]      px_prev,
  input  logic [COORD_BITS-1:0]      py_prev,
  input  logic [IDX_W-1:0]           idx_prev,
  input  logic [COORD_BITS-1:0]      cx_prev,
  input  logic [COORD_BITS-1:0]      cy_prev,
  input  logic [CNT_W-1:0]           used_prev,
  output pbc_pkg::pbc_tok_ctrl_t     ctrl,
  output logic [COORD_BITS-1:0]      px,
  output logic [COORD_BITS-1:0]      py,
  output logic [IDX_W-1:0]           idx,
  output logic [COORD_BITS-1:0]      cx,
  output logic [COORD_BITS-1:0]      cy,
  output logic [CNT_W-1:0]           used
);
  import pbc_pkg::*;

  localparam int CMP_W = (COORD_BITS > FIELD_W) ? COORD_BITS : FIELD_W;

  // Box held by this cell.
  logic [COORD_BITS-1:0] min_x, max_x, min_y, max_y;
  logic [COORD_BITS-1:0] min_x_next, max_x_next, min_y_next, max_y_next;

  logic live, is_free, hit, open_box;
  logic near_x_min, near_x_max, near_y_min, near_y_max;
  logic [COORD_BITS:0] sum_x, sum_y;

  pbc_tok_ctrl_t         ctrl_next;
  logic [IDX_W-1:0]      idx_next;
  logic [COORD_BITS-1:0] cx_next, cy_next;
  logic [CNT_W-1:0]      used_next;

  // True when |a - b| is strictly below the threshold.
  function automatic logic near(input logic [COORD_BITS-1:0] a,
                                input logic [COORD_BITS-1:0] b,
                                input logic [FIELD_W-1:0] thr);
    logic [COORD_BITS-1:0] diff;
    diff = (a > b) ? (a - b) : (b - a);
    return CMP_W'(diff) < CMP_W'(thr);
  endfunction

  // Corner tests: each corner pairs one x edge with one y edge.
  always_comb begin
    near_x_min = near(px_prev, min_x, x_threshold);
    near_x_max = near(px_prev, max_x, x_threshold);
    near_y_min = near(py_prev, min_y, y_threshold);
    near_y_max = near(py_prev, max_y, y_threshold);
    live       = CNT_W'(CELL_ID) < used_prev;
    is_free    = CNT_W'(CELL_ID) == used_prev;
    hit        = ctrl_prev.valid && !ctrl_prev.found && live &&
                 ((near_x_min || near_x_max) && (near_y_min || near_y_max));
    open_box   = ctrl_prev.valid && !ctrl_prev.found && is_free;
  end

  // Grown or freshly opened box.
  always_comb begin
    min_x_next = min_x;
    max_x_next = max_x;
    min_y_next = min_y;
    max_y_next = max_y;
    if (open_box) begin
      min_x_next = px_prev;
      max_x_next = px_prev;
      min_y_next = py_prev;
      max_y_next = py_prev;
    end else if (hit) begin
      if (px_prev < min_x) min_x_next = px_prev;
      if (px_prev > max_x) max_x_next = px_prev;
      if (py_prev < min_y) min_y_next = py_prev;
      if (py_prev > max_y) max_y_next = py_prev;
    end
    sum_x = {1'b0, min_x_next} + {1'b0, max_x_next};
    sum_y = {1'b0, min_y_next} + {1'b0, max_y_next};
  end

  // Token leaving this cell.
  always_comb begin
    ctrl_next = ctrl_prev;
    idx_next  = idx_prev;
    cx_next   = cx_prev;
    cy_next   = cy_prev;
    used_next = used_prev;
    if (hit || open_box) begin
      ctrl_next.found  = 1'b1;
      ctrl_next.opened = open_box;
      idx_next         = IDX_W'(CELL_ID);
      cx_next          = sum_x[COORD_BITS:1];
      cy_next          = sum_y[COORD_BITS:1];
      if (open_box) begin
        used_next = used_prev + CNT_W'(1);
      end
    end
  end

  // Box storage.
  always_ff @(posedge clk) begin
    if (hit || open_box) begin
      min_x <= min_x_next;
      max_x <= max_x_next;
      min_y <= min_y_next;
      max_y <= max_y_next;
    end
  end

  // Token register.
  always_ff @(posedge clk) begin
    if (rst) begin
      ctrl <= '0;
    end else begin
      ctrl <= ctrl_next;
    end
  end

  always_ff @(posedge clk) begin
    px   <= px_prev;
    py   <= py_prev;
    idx  <= idx_next;
    cx   <= cx_next;
    cy   <= cy_next;
    used <= used_next;
  end

endmodule
